// ===== rtl/core/trb_pkg.sv =====
// package for the timed retry buffer: sizes, codes and shared types
// no dependencies
`default_nettype none

package trb_pkg;

  localparam int SlotCount = 16;
  localparam int IdxW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int CntW      = $clog2(SlotCount + 1);

  localparam int HandleW   = 16;
  localparam int TimeW     = 64;
  localparam int PenaltyW  = 32;
  localparam int FreeW     = 5;
  localparam int StatusW   = 3;

  localparam int InDataW   = TimeW + HandleW + PenaltyW + TimeW;
  localparam int OutFieldW = HandleW + TimeW + TimeW + FreeW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int OutPadW   = OutDataW - OutFieldW;

  localparam int AddrW     = 3;
  localparam int RegIdxW   = 1;
  localparam logic [RegIdxW-1:0] RegRetryEnable = 1'b0;

  typedef enum logic {
    OpFetch  = 1'b0,
    OpInsert = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StReady    = 3'd0,
    StTakeNew  = 3'd1,
    StFullWait = 3'd2,
    StInserted = 3'd3,
    StRejected = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    EngIdle,
    EngScanFetch,
    EngScanInsert,
    EngFinish
  } eng_state_e;

  typedef struct packed {
    op_e                 op;
    logic [TimeW-1:0]    now;
    logic [HandleW-1:0]  handle;
    logic [PenaltyW-1:0] penalty;
    logic [TimeW-1:0]    start;
  } req_t;

  typedef struct packed {
    logic [TimeW-1:0]   start;
    logic [TimeW-1:0]   ready;
    logic [HandleW-1:0] handle;
  } slot_t;

  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   start;
    logic [TimeW-1:0]   wait_until;
    logic [FreeW-1:0]   free_count;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/trb_slot_ram.sv =====
// slot store: handle, ready time and start time per slot, one write and one read port
// depends on trb_pkg
`default_nettype none

module trb_slot_ram (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [trb_pkg::IdxW-1:0]      waddr_i,
  input  wire trb_pkg::slot_t                wdata_i,
  input  wire logic                          re_i,
  input  wire logic [trb_pkg::IdxW-1:0]      raddr_i,
  output trb_pkg::slot_t                     rdata_o
);

  trb_pkg::slot_t mem_q [trb_pkg::SlotCount];
  trb_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/trb_engine.sv =====
// retry engine: valid bits, free count and the slot scan over the slot store
// depends on trb_pkg and trb_slot_ram
`default_nettype none

module trb_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           enable_i,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire trb_pkg::req_t  req_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output trb_pkg::res_t       res_o
);

  localparam int IdxW  = trb_pkg::IdxW;
  localparam int CntW  = trb_pkg::CntW;
  localparam int FreeW = trb_pkg::FreeW;
  localparam int TimeW = trb_pkg::TimeW;
  localparam int Slots = trb_pkg::SlotCount;

  trb_pkg::eng_state_e state_q, state_d;
  logic [Slots-1:0]    valid_q, valid_d;
  logic [CntW-1:0]     empty_q, empty_d;
  logic [CntW-1:0]     iss_q, iss_d;
  logic                chk_v_q, chk_v_d;
  logic [IdxW-1:0]     chk_idx_q, chk_idx_d;
  logic [TimeW-1:0]    earliest_q, earliest_d, earliest_n;
  trb_pkg::req_t       req_q, req_d;
  trb_pkg::res_t       res_q, res_d;

  logic           rd_en;
  logic           wr_en;
  trb_pkg::slot_t wr_data;
  trb_pkg::slot_t rd_data;
  logic           hit;
  logic           last;
  logic           iss_free;

  trb_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (iss_q[IdxW-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  assign hit        = chk_v_q && valid_q[chk_idx_q] && (req_q.now > rd_data.ready);
  assign last       = (chk_idx_q == IdxW'(Slots - 1));
  assign iss_free   = !valid_q[iss_q[IdxW-1:0]];
  assign earliest_n = (valid_q[chk_idx_q] && (rd_data.ready < earliest_q)) ?
                      rd_data.ready : earliest_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      trb_pkg::EngIdle: begin
        if (req_valid_i) begin
          if (!enable_i) begin
            state_d = trb_pkg::EngFinish;
          end else if (req_i.op == trb_pkg::OpInsert) begin
            state_d = (empty_q == '0) ? trb_pkg::EngFinish : trb_pkg::EngScanInsert;
          end else begin
            state_d = trb_pkg::EngScanFetch;
          end
        end
      end
      trb_pkg::EngScanFetch: begin
        if (chk_v_q && (hit || last)) begin
          state_d = trb_pkg::EngFinish;
        end
      end
      trb_pkg::EngScanInsert: begin
        if (iss_free) begin
          state_d = trb_pkg::EngFinish;
        end
      end
      trb_pkg::EngFinish: begin
        if (res_ready_i) begin
          state_d = trb_pkg::EngIdle;
        end
      end
      default: state_d = trb_pkg::EngIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_ready_o = (state_q == trb_pkg::EngIdle);
    res_valid_o = (state_q == trb_pkg::EngFinish);
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = '{start: req_q.start,
                    ready: req_q.now + TimeW'(req_q.penalty),
                    handle: req_q.handle};
    valid_d     = valid_q;
    empty_d     = empty_q;
    iss_d       = iss_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    earliest_d  = earliest_q;
    req_d       = req_q;
    res_d       = res_q;
    case (state_q)
      trb_pkg::EngIdle: begin
        if (req_valid_i) begin
          req_d      = req_i;
          iss_d      = '0;
          earliest_d = '1;
          res_d      = '0;
          res_d.free_count = FreeW'(empty_q);
          if (!enable_i) begin
            res_d.status = (req_i.op == trb_pkg::OpFetch) ?
                           trb_pkg::StTakeNew : trb_pkg::StRejected;
          end else if (req_i.op == trb_pkg::OpInsert) begin
            res_d.status = trb_pkg::StRejected;
          end else begin
            res_d.status = trb_pkg::StTakeNew;
          end
        end
      end
      trb_pkg::EngScanFetch: begin
        rd_en     = (iss_q < CntW'(Slots));
        chk_v_d   = rd_en;
        chk_idx_d = iss_q[IdxW-1:0];
        if (rd_en) begin
          iss_d = iss_q + 1'b1;
        end
        if (chk_v_q) begin
          if (hit) begin
            chk_v_d            = 1'b0;
            valid_d[chk_idx_q] = 1'b0;
            empty_d            = empty_q + 1'b1;
            res_d.status       = trb_pkg::StReady;
            res_d.handle       = rd_data.handle;
            res_d.start        = rd_data.start;
            res_d.free_count   = FreeW'(empty_q + 1'b1);
          end else begin
            earliest_d = earliest_n;
            if (last) begin
              chk_v_d = 1'b0;
              if (empty_q == '0) begin
                res_d.status     = trb_pkg::StFullWait;
                res_d.wait_until = earliest_n;
              end else begin
                res_d.status = trb_pkg::StTakeNew;
              end
            end
          end
        end
      end
      trb_pkg::EngScanInsert: begin
        if (iss_free) begin
          wr_en                     = 1'b1;
          valid_d[iss_q[IdxW-1:0]]  = 1'b1;
          empty_d                   = empty_q - 1'b1;
          res_d.status              = trb_pkg::StInserted;
          res_d.free_count          = FreeW'(empty_q - 1'b1);
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
      trb_pkg::EngFinish: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trb_pkg::EngIdle;
      valid_q <= '0;
      empty_q <= CntW'(Slots);
      iss_q   <= '0;
      chk_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      empty_q <= empty_d;
      iss_q   <= iss_d;
      chk_v_q <= chk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    earliest_q <= earliest_d;
    req_q      <= req_d;
    res_q      <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/timed_retry_buffer.sv =====
// timed retry buffer top level: register port, request unpacking, result register
// depends on trb_pkg and trb_engine
// bypass and rejected insert skip the scan; insert scans up to the lowest free slot;
// fetch scans up to all slots, one slot read from the slot store per cycle
// one request in flight; next request taken in the cycle after its result moves out
// reset clears all valid bits at once and disables the table; no clearing pass
`default_nettype none

module timed_retry_buffer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // now_time, item_handle, penalty_delay, first_start_time
  input  wire logic [trb_pkg::InDataW-1:0]    s_axis_tdata,
  // operation
  input  wire logic [0:0]                     s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_handle, out_start_time, wait_until, free_count, zero pad
  output logic [trb_pkg::OutDataW-1:0]        m_axis_tdata,
  // status
  output logic [trb_pkg::StatusW-1:0]         m_axis_tuser,
  // register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [trb_pkg::AddrW-1:0]      paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int HandleW  = trb_pkg::HandleW;
  localparam int TimeW    = trb_pkg::TimeW;
  localparam int PenaltyW = trb_pkg::PenaltyW;
  localparam int OutPadW  = trb_pkg::OutPadW;
  localparam int AddrW    = trb_pkg::AddrW;

  logic          enable_q, enable_d;
  logic          out_v_q, out_v_d;
  trb_pkg::res_t out_q;
  trb_pkg::req_t req;
  trb_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrW-1:2] == trb_pkg::RegRetryEnable);
  assign prdata  = reg_sel ? {31'b0, enable_q} : 32'b0;

  always_comb begin
    enable_d = enable_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      enable_d = pwdata[0];
    end
  end

  always_comb begin
    req.op      = trb_pkg::op_e'(s_axis_tuser[0]);
    req.now     = s_axis_tdata[TimeW-1:0];
    req.handle  = s_axis_tdata[TimeW +: HandleW];
    req.penalty = s_axis_tdata[TimeW + HandleW +: PenaltyW];
    req.start   = s_axis_tdata[TimeW + HandleW + PenaltyW +: TimeW];
  end

  trb_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_v_q || m_axis_tready;

  always_comb begin
    out_v_d = out_v_q;
    if (res_ready) begin
      out_v_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      enable_q <= enable_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, out_q.free_count, out_q.wait_until,
                          out_q.start, out_q.handle};

endmodule

`default_nettype wire

// ===== tb/sv/trb_checker.sv =====
// checker for the timed retry buffer: follows the request, result and register ports,
// keeps its own copy of the slot table and compares every result with its prediction
// depends on trb_pkg
module trb_checker
  import trb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  input  wire logic                s_ready_i,
  input  wire logic [InDataW-1:0]  s_data_i,
  input  wire logic [0:0]          s_user_i,
  input  wire logic                m_valid_i,
  input  wire logic                m_ready_i,
  input  wire logic [OutDataW-1:0] m_data_i,
  input  wire logic [StatusW-1:0]  m_user_i,
  input  wire logic                psel_i,
  input  wire logic                penable_i,
  input  wire logic                pwrite_i,
  input  wire logic                pready_i,
  input  wire logic [AddrW-1:0]    paddr_i,
  input  wire logic [31:0]         pwdata_i,
  input  wire logic [31:0]         prdata_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam logic [AddrW-1:0] EnableAddr = {RegRetryEnable, 2'b00};

  localparam int INowLo    = 0;
  localparam int IHandleLo = TimeW;
  localparam int IPenLo    = TimeW + HandleW;
  localparam int IStartLo  = TimeW + HandleW + PenaltyW;

  localparam int RHandleLo = 0;
  localparam int RStartLo  = HandleW;
  localparam int RWaitLo   = HandleW + TimeW;
  localparam int RFreeLo   = HandleW + 2 * TimeW;

  logic               table_on;
  logic               slot_busy  [SlotCount];
  logic [HandleW-1:0] slot_handle[SlotCount];
  logic [TimeW-1:0]   slot_ready [SlotCount];
  logic [TimeW-1:0]   slot_start [SlotCount];
  int                 free_slots;
  res_t               due_q[$];
  int                 fails;

  function automatic res_t predict_retry(input op_e op, input logic [TimeW-1:0] now,
                                         input logic [HandleW-1:0] handle,
                                         input logic [PenaltyW-1:0] penalty,
                                         input logic [TimeW-1:0] start);
    res_t             r;
    logic [TimeW-1:0] earliest;
    bit               hit;
    r        = '0;
    earliest = '1;
    hit      = 1'b0;
    if (!table_on) begin
      r.status = (op == OpFetch) ? StTakeNew : StRejected;
    end else if (op == OpFetch) begin
      for (int i = 0; i < SlotCount; i++) begin
        if (!hit && slot_busy[i]) begin
          if (now > slot_ready[i]) begin
            r.handle     = slot_handle[i];
            r.start      = slot_start[i];
            slot_busy[i] = 1'b0;
            free_slots++;
            hit = 1'b1;
          end else if (slot_ready[i] < earliest) begin
            earliest = slot_ready[i];
          end
        end
      end
      if (hit) begin
        r.status = StReady;
      end else if (free_slots == 0) begin
        r.status     = StFullWait;
        r.wait_until = earliest;
      end else begin
        r.status = StTakeNew;
      end
    end else begin
      r.status = StRejected;
      for (int i = 0; i < SlotCount; i++) begin
        if (r.status == StRejected && !slot_busy[i]) begin
          slot_busy[i]   = 1'b1;
          slot_handle[i] = handle;
          slot_ready[i]  = now + TimeW'(penalty);
          slot_start[i]  = start;
          free_slots--;
          r.status = StInserted;
        end
      end
    end
    r.free_count = FreeW'(free_slots);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (fails < 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
    fails++;
  endtask

  task automatic check_result();
    res_t want;
    if (due_q.size() == 0) begin
      if (fails < 10) $display("result %h/%h with no request outstanding", m_user_i, m_data_i);
      fails++;
    end else begin
      want = due_q.pop_front();
      if (m_user_i !== want.status) note_mismatch("status", 64'(want.status), 64'(m_user_i));
      if (m_data_i[RHandleLo +: HandleW] !== want.handle)
        note_mismatch("out_handle", 64'(want.handle), 64'(m_data_i[RHandleLo +: HandleW]));
      if (m_data_i[RStartLo +: TimeW] !== want.start)
        note_mismatch("out_start_time", want.start, m_data_i[RStartLo +: TimeW]);
      if (m_data_i[RWaitLo +: TimeW] !== want.wait_until)
        note_mismatch("wait_until", want.wait_until, m_data_i[RWaitLo +: TimeW]);
      if (m_data_i[RFreeLo +: FreeW] !== want.free_count)
        note_mismatch("free_count", 64'(want.free_count), 64'(m_data_i[RFreeLo +: FreeW]));
      if (m_data_i[OutDataW-1:OutFieldW] !== '0)
        note_mismatch("pad", 64'd0, 64'(m_data_i[OutDataW-1:OutFieldW]));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_on   = 1'b0;
      free_slots = SlotCount;
      fails      = 0;
      for (int i = 0; i < SlotCount; i++) slot_busy[i] = 1'b0;
      due_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        due_q.push_back(predict_retry(op_e'(s_user_i[0]), s_data_i[INowLo +: TimeW],
                                      s_data_i[IHandleLo +: HandleW],
                                      s_data_i[IPenLo +: PenaltyW],
                                      s_data_i[IStartLo +: TimeW]));
      end
      if (m_valid_i && m_ready_i) check_result();
      if (psel_i && penable_i && pready_i && paddr_i == EnableAddr) begin
        if (pwrite_i) begin
          table_on = pwdata_i[0];
        end else if (prdata_i !== {31'b0, table_on}) begin
          note_mismatch("prdata", 64'(table_on), 64'(prdata_i));
        end
      end
      fail_count_o <= fails;
      pending_o    <= due_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_timed_retry_buffer.sv =====
// top of the timed retry buffer testbench: clock, reset, register set-up and request stimulus
// depends on trb_pkg, timed_retry_buffer and trb_checker
module tb_timed_retry_buffer;
  import trb_pkg::*;

  localparam logic [AddrW-1:0] AddrEnable = {RegRetryEnable, 2'b00};
  localparam logic [AddrW-1:0] AddrNoReg  = AddrEnable + 3'd4;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tready = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [31:0]         pwdata        = '0;
  wire                 s_axis_tready;
  wire                 m_axis_tvalid;
  wire [OutDataW-1:0]  m_axis_tdata;
  wire [StatusW-1:0]   m_axis_tuser;
  wire [31:0]          prdata;
  wire                 pready;
  int                  fail_count;
  int                  pending;

  int                  gap_pct      = 0;
  int                  stall_pct    = 0;
  int                  stall_left   = 0;
  bit                  calm         = 1'b0;
  bit                  hold_results = 1'b0;
  logic [TimeW-1:0]    sim_clock    = 64'd900;

  timed_retry_buffer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  trb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, one long hold-off so the input backs up
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_results = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(input op_e op, input logic [TimeW-1:0] now,
                          input logic [HandleW-1:0] handle,
                          input logic [PenaltyW-1:0] penalty,
                          input logic [TimeW-1:0] start);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {start, penalty, handle, now};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic push_random(input int ins_pct);
    op_e               op;
    logic [TimeW-1:0]  now;
    logic [PenaltyW-1:0] pen;
    int                sel;
    op = ($urandom_range(0, 99) < ins_pct) ? OpInsert : OpFetch;
    sim_clock += $urandom_range(0, 40);
    sel = $urandom_range(0, 99);
    if (sel < 85) now = sim_clock;
    else if (sel < 95) now = {$urandom, $urandom};
    else now = sel[0] ? '1 : '0;
    sel = $urandom_range(0, 99);
    if (sel < 70) pen = $urandom_range(0, 300);
    else if (sel < 90) pen = $urandom;
    else pen = sel[0] ? '1 : '0;
    push_req(op, now, 16'($urandom), pen, {$urandom, $urandom});
  endtask

  // let the table go idle before touching the register
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SlotCount + 4) @(posedge clk_i);
  endtask

  task automatic reg_access(input bit wr, input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int ins_pct;
    bit en;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bypass after reset
    reg_access(1'b0, AddrEnable, '0);
    push_req(OpFetch, '1, '1, '1, '1);
    push_req(OpInsert, '1, '1, '1, '1);
    push_req(OpInsert, '0, '0, '0, '0);
    drain_requests();
    reg_access(1'b1, AddrEnable, 32'hFFFF_FFFE);
    reg_access(1'b1, AddrNoReg, '1);
    reg_access(1'b0, AddrEnable, '0);
    push_req(OpInsert, 64'd5, 16'h1234, 32'd7, 64'd9);
    drain_requests();
    reg_access(1'b1, AddrEnable, 32'd1);
    reg_access(1'b0, AddrEnable, '0);

    // empty fetch, then fill: wrapping ready time, zero ready time, then ordinary slots
    push_req(OpFetch, '1, '1, '1, '1);
    push_req(OpInsert, '1, '1, '1, '1);
    push_req(OpInsert, '0, '0, '0, '0);
    for (int i = 2; i < SlotCount; i++) begin
      push_req(OpInsert, 64'd1000 + i, HandleW'(i), PenaltyW'(i), {$urandom, $urandom});
    end
    push_req(OpInsert, 64'd50, 16'hBEEF, 32'd1, 64'd77);
    // ready time equal to now is not ready, full table gives the wait time
    push_req(OpFetch, '0, '0, '0, '0);
    push_req(OpFetch, 64'd1, '0, '0, '0);
    push_req(OpFetch, '1, '0, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      drain_requests();
      en = (ph != 3);
      reg_access(1'b1, AddrEnable, {31'($urandom_range(0, 32'h7FFF_FFFF)), en});
      if (ph % 2 == 0) reg_access(1'b0, AddrEnable, '0);
      calm      = (ph == 7);
      gap_pct   = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 15 : 40;
      stall_pct = ((ph + 1) % 3 == 0) ? 0 : ((ph + 1) % 3 == 1) ? 15 : 40;
      if (ph == 2) hold_results = 1'b1;
      ins_pct = 50;
      for (int n = 0; n < 160; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       ins_pct = 20;
            1:       ins_pct = 50;
            default: ins_pct = 80;
          endcase
        end
        push_random(ins_pct);
      end
    end

    drain_requests();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
